// ----- design/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, types and register addresses of the buddy allocator
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int LEVEL_COUNT  = 10;
   localparam int HEADER_BYTES = 8;
   localparam int NODE_COUNT   = 1 << LEVEL_COUNT;
   localparam int LEAF_COUNT   = 1 << (LEVEL_COUNT - 1);
   localparam int NODE_BITS    = LEVEL_COUNT;
   localparam int LEAF_BITS    = LEVEL_COUNT - 1;
   localparam int LVL_BITS     = 4;
   localparam int BYTES_BITS   = 22;
   localparam int MB_BITS      = 13;
   localparam int TOTAL_BITS   = 26;
   localparam int ADDR_BITS    = 3;

   localparam logic [ADDR_BITS-1:0] REG_LEVELS = 3'd0;
   localparam logic [ADDR_BITS-1:0] REG_MINBLK = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOSPC  = 2'd1;
   localparam logic [1:0] ST_BADOFF = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DIV, S_LVL, S_SRCH_RD, S_SRCH_CHK,
      S_SPLIT, S_FIN_ALLOC, S_FDIV, S_FCHK, S_FLVL_RD, S_FLVL_CHK,
      S_MERGE_RD, S_MERGE_CHK, S_MERGE_WR, S_RESULT
   } state_type;

endpackage

// ----- design/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/buddy_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// binary buddy allocator with its node tree held in block memory
// ----------------------------------------------------------------------------
// a request word is taken when start is high and busy low; action 0
// allocates request_bytes, action 1 frees free_offset. the result word
// appears for one cycle with rsp_done high and cannot be stalled.
// node state is a 2-bit word per node (free, allocated) in one ram and the
// level of each allocated block in a second ram keyed by its first leaf.
// an allocate divides total size by the request plus header with a
// 26-step restoring divider, scans the tree level by level, one node at a
// time (ram read then check), then splits one level per cycle. a free
// divides the offset less the header by the block size (22 steps), checks
// the level entry and the node, then merges one level per buddy read and
// check and finally marks the merged block free. a request refused at once
// goes straight to the result. one item at a time, busy stays high
// throughout. after reset, and after every configuration write, a
// clearing pass wipes the node ram; start is not taken meanwhile. the csr
// port (levels_in_use at 0, min_block_bytes at 4) takes writes only while
// no request is in flight.
module buddy_block_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [21:0]                     req_request_bytes,
   input  logic [21:0]                     req_free_offset,
   output logic                            rsp_done,
   output logic [1:0]                      rsp_status,
   output logic [21:0]                     rsp_data_offset,
   output logic [3:0]                      rsp_block_level,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bba_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import bba_pkg::*;

   state_type state_ff, state_in;
   logic [LVL_BITS-1:0]   lvls_ff, lvls_in;
   logic [MB_BITS-1:0]    mb_ff, mb_in;
   logic [NODE_BITS-1:0]  n_ff, n_in;
   logic [LVL_BITS-1:0]   d_ff, d_in, lvl_ff, lvl_in;
   logic [TOTAL_BITS-1:0] num_ff, num_in;
   logic [TOTAL_BITS:0]   rem_ff, rem_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  act_ff, act_in, found_ff, found_in;
   logic [LEAF_BITS:0]    leaf_ff, leaf_in;
   logic [1:0]            st_ff, st_in;
   logic [21:0]           off_ff, off_in;
   logic                  done_ff, done_in;

   logic                  nwe, lwe;
   logic [NODE_BITS-1:0]  naddr;
   logic [1:0]            nwdata, nrdata;
   logic [LEAF_BITS-1:0]  laddr;
   logic [LVL_BITS-1:0]   lwdata, lrdata;

   bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_node (
      .clock(clock), .we(nwe), .addr(naddr), .wdata(nwdata), .rdata(nrdata));
   bba_ram #(.WIDTH(LVL_BITS), .DEPTH(LEAF_COUNT)) u_leaf (
      .clock(clock), .we(lwe), .addr(laddr), .wdata(lwdata), .rdata(lrdata));

   logic cfg_wr;
   logic [MB_BITS-1:0]    mbe;
   logic [TOTAL_BITS-1:0] total;
   logic [TOTAL_BITS:0]   trial;
   logic [LVL_BITS-1:0]   lg;
   logic [NODE_BITS-1:0]  last_n;
   logic [LVL_BITS-1:0]   sh;
   logic [LEAF_BITS:0]    fin_leaf;

   assign cfg_wr   = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign mbe      = (mb_ff == '0) ? MB_BITS'(1) : mb_ff;
   assign total    = TOTAL_BITS'(mbe) << lvls_ff;
   assign trial    = {rem_ff[TOTAL_BITS-1:0], num_ff[TOTAL_BITS-1]};
   assign sh       = lvls_ff - lvl_ff;
   assign fin_leaf = (LEAF_BITS+1)'(n_ff - (NODE_BITS'(1) << lvl_ff)) << sh;

   always_comb begin
      prdata = '0;
      case (paddr)
         REG_LEVELS: prdata = 32'(lvls_ff);
         REG_MINBLK: prdata = 32'(mb_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      lg = '0;
      for (int i = 0; i < TOTAL_BITS; i++) begin
         if (num_ff[i]) lg = LVL_BITS'(i > 15 ? 15 : i);
      end
   end

   always_comb begin
      state_in = state_ff;
      lvls_in = lvls_ff; mb_in = mb_ff;
      n_in = n_ff; d_in = d_ff; lvl_in = lvl_ff;
      num_in = num_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      act_in = act_ff; found_in = found_ff; leaf_in = leaf_ff;
      st_in = st_ff; off_in = off_ff; done_in = 1'b0;
      nwe = 1'b0; naddr = n_ff; nwdata = 2'b00;
      lwe = 1'b0; laddr = leaf_ff[LEAF_BITS-1:0]; lwdata = lvl_ff;
      last_n = NODE_BITS'((2 << d_ff) - 1);
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            nwe = 1'b1; naddr = n_ff;
            nwdata = (n_ff == NODE_BITS'(1)) ? 2'b10 : 2'b00;
            n_in = n_ff + 1'b1;
            if (n_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               act_in = req_action;
               rem_in = '0; cnt_in = '0;
               if (req_action == ACT_ALLOC) begin
                  num_in = TOTAL_BITS'(total);
                  off_in = req_request_bytes + 22'(HEADER_BYTES);
                  if (({1'b0, req_request_bytes} + 23'(HEADER_BYTES)) > 23'(total)) begin
                     st_in = ST_NOSPC; state_in = S_RESULT;
                  end else if (({1'b0, req_request_bytes} + 23'(HEADER_BYTES)) == 23'd0) begin
                     lvl_in = lvls_ff; state_in = S_LVL;
                  end else state_in = S_DIV;
               end else begin
                  if (req_free_offset < 22'(HEADER_BYTES)) begin
                     st_in = ST_BADOFF; state_in = S_RESULT;
                  end else begin
                     num_in = TOTAL_BITS'(req_free_offset - 22'(HEADER_BYTES)) << 4;
                     state_in = S_FDIV;
                  end
               end
            end
         end
         S_DIV: begin
            if (trial >= {5'd0, off_ff}) begin
               rem_in = trial - {5'd0, off_ff};
               num_in = {num_ff[TOTAL_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               num_in = {num_ff[TOTAL_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(TOTAL_BITS-1)) state_in = S_LVL;
         end
         S_LVL: begin
            if (act_ff == ACT_ALLOC && ({1'b0, off_ff} != 23'd0)) begin
               lvl_in = (lg > lvls_ff) ? lvls_ff : lg;
               d_in = (lg > lvls_ff) ? lvls_ff : lg;
               n_in = NODE_BITS'(1) << ((lg > lvls_ff) ? lvls_ff : lg);
            end else begin
               d_in = lvl_ff; n_in = NODE_BITS'(1) << lvl_ff;
            end
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            naddr = n_ff; state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (nrdata[1]) begin
               nwe = 1'b1; naddr = n_ff; nwdata = 2'b00;
               state_in = (d_ff == lvl_ff) ? S_FIN_ALLOC : S_SPLIT;
               if (d_ff != lvl_ff) begin
                  n_in = {n_ff[NODE_BITS-2:0], 1'b0};
                  d_in = d_ff + 1'b1;
               end
            end else if (n_ff != last_n) begin
               n_in = n_ff + 1'b1; state_in = S_SRCH_RD;
            end else if (d_ff != '0) begin
               d_in = d_ff - 1'b1;
               n_in = NODE_BITS'(1) << (d_ff - 1'b1);
               state_in = S_SRCH_RD;
            end else begin
               st_in = ST_NOSPC; state_in = S_RESULT;
            end
         end
         S_SPLIT: begin
            nwe = 1'b1; naddr = n_ff | NODE_BITS'(1); nwdata = 2'b10;
            if (d_ff == lvl_ff) state_in = S_FIN_ALLOC;
            else begin
               n_in = {n_ff[NODE_BITS-2:0], 1'b0};
               d_in = d_ff + 1'b1;
            end
         end
         S_FIN_ALLOC: begin
            nwe = 1'b1; naddr = n_ff; nwdata = 2'b01;
            leaf_in = fin_leaf;
            laddr = fin_leaf[LEAF_BITS-1:0];
            lwe = 1'b1; lwdata = lvl_ff;
            off_in = 22'(fin_leaf) * 22'(mbe) + 22'(HEADER_BYTES);
            st_in = ST_OK; state_in = S_RESULT;
         end
         S_FDIV: begin
            if (trial >= {14'd0, mbe}) begin
               rem_in = trial - {14'd0, mbe};
               num_in = {num_ff[TOTAL_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               num_in = {num_ff[TOTAL_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd21) state_in = S_FCHK;
         end
         S_FCHK: begin
            if (rem_ff != '0 || (num_ff[21:0] >> lvls_ff) != 22'd0) begin
               st_in = ST_BADOFF; state_in = S_RESULT;
            end else begin
               leaf_in = (LEAF_BITS+1)'(num_ff[21:0]);
               state_in = S_FLVL_RD;
            end
         end
         S_FLVL_RD: begin
            laddr = leaf_ff[LEAF_BITS-1:0]; state_in = S_FLVL_CHK;
            lvl_in = '0;
         end
         S_FLVL_CHK: begin
            lvl_in = lrdata;
            if (lrdata > lvls_ff ||
                ((leaf_ff & ((LEAF_BITS+1)'(1) << (lvls_ff - lrdata)) - 1'b1) != '0)) begin
               st_in = ST_BADOFF; state_in = S_RESULT;
            end else begin
               n_in = (NODE_BITS'(1) << lrdata) +
                      NODE_BITS'(leaf_ff >> (lvls_ff - lrdata));
               found_in = 1'b0;
               state_in = S_MERGE_RD;
            end
         end
         S_MERGE_RD: begin
            naddr = found_ff ? (n_ff ^ NODE_BITS'(1)) : n_ff;
            state_in = S_MERGE_CHK;
         end
         S_MERGE_CHK: begin
            if (!found_ff) begin
               if (!nrdata[0]) begin
                  st_in = ST_BADOFF; state_in = S_RESULT;
               end else begin
                  // block released, marked free once merging stops
                  nwe = 1'b1; nwdata = 2'b00; found_in = 1'b1;
                  st_in = ST_OK;
                  state_in = (n_ff == NODE_BITS'(1)) ? S_MERGE_WR : S_MERGE_RD;
               end
            end else if (nrdata[1]) begin
               nwe = 1'b1; naddr = n_ff ^ NODE_BITS'(1); nwdata = 2'b00;
               n_in = n_ff >> 1;
               state_in = ((n_ff >> 1) == NODE_BITS'(1)) ? S_MERGE_WR : S_MERGE_RD;
            end else state_in = S_MERGE_WR;
         end
         S_MERGE_WR: begin
            nwe = 1'b1; naddr = n_ff; nwdata = 2'b10;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            done_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (cfg_wr && (state_ff == S_IDLE || state_ff == S_CLEAR)) begin
         if (paddr == REG_LEVELS) begin
            lvls_in = (pwdata[3:0] > 4'(LEVEL_COUNT-1)) ? 4'(LEVEL_COUNT-1) : pwdata[3:0];
         end
         if (paddr == REG_LEVELS || paddr == REG_MINBLK) begin
            if (paddr == REG_MINBLK) mb_in = pwdata[MB_BITS-1:0];
            n_in = '0; state_in = S_CLEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         lvls_ff  <= 4'd9;
         mb_ff    <= 13'd64;
         n_ff     <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvls_ff  <= lvls_in;
         mb_ff    <= mb_in;
         n_ff     <= n_in;
         done_ff  <= done_in;
      end
      d_ff <= d_in; lvl_ff <= lvl_in; num_ff <= num_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; act_ff <= act_in; found_ff <= found_in;
      leaf_ff <= leaf_in; st_ff <= st_in; off_ff <= off_in;
   end

   assign rsp_done        = done_ff;
   assign rsp_status      = st_ff;
   assign rsp_data_offset = (st_ff == ST_OK && act_ff == ACT_ALLOC) ? off_ff : 22'd0;
   assign rsp_block_level = (st_ff == ST_OK) ? lvl_ff : 4'd0;
endmodule

// ----- design/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the buddy allocator
// ----------------------------------------------------------------------------
module bba_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_done,
   input logic [1:0]  rsp_status,
   input logic [21:0] rsp_data_offset,
   input logic [3:0]  rsp_block_level
);
   import bba_pkg::*;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_done |-> $past(busy)) else $error("result without work");
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_done |=> !rsp_done) else $error("result held");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_done && rsp_status != ST_OK) |-> (rsp_data_offset == 22'd0 &&
      rsp_block_level == 4'd0)) else $error("failed result not zero");
endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_done(rsp_done), .rsp_status(rsp_status),
   .rsp_data_offset(rsp_data_offset), .rsp_block_level(rsp_block_level));

// ----- bench/buddy_block_allocator_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_top_test
// self-checking bench for the buddy allocator
// ----------------------------------------------------------------------------
// a tracker class keeps its own copy of the node tree and predicts each
// result word from the accepted request; result words are compared field by
// field in order. directed corner cases come first, then random traffic of
// mostly valid allocate/free sequences over several register settings.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top_test;
   import bba_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [21:0] offset;
      logic [3:0]  level;
   } result_word_type;

   class alloc_tracker;
      bit          node_free [NODE_COUNT];
      bit          node_taken [NODE_COUNT];
      logic [3:0]  leaf_level [LEAF_COUNT];
      bit          leaf_written [LEAF_COUNT];
      int unsigned depth;
      int unsigned blk_bytes;
      result_word_type expected_words [$];
      int          live [$];
      int          dead [$];
      int          fails;

      function void clear_tree();
         foreach (node_free[i]) begin
            node_free[i] = 0;
            node_taken[i] = 0;
         end
         node_free[1] = 1;
         live.delete();
         dead.delete();
      endfunction

      function void power_up();
         depth = 9;
         blk_bytes = 64;
         fails = 0;
         foreach (leaf_written[i]) leaf_written[i] = 0;
         clear_tree();
      endfunction

      function void write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] value);
         if (addr == REG_LEVELS) begin
            depth = (value[3:0] > LEVEL_COUNT - 1) ? LEVEL_COUNT - 1 : value[3:0];
         end else begin
            blk_bytes = value[12:0];
         end
         clear_tree();
      endfunction

      function longint unsigned unit_bytes();
         return (blk_bytes == 0) ? 1 : blk_bytes;
      endfunction

      function longint unsigned total_bytes();
         return (longint'(1) << depth) * unit_bytes();
      endfunction

      // a free that would read a level entry never written
      function bit reads_unwritten(logic [21:0] off);
         longint unsigned leaf;
         if (off < HEADER_BYTES) return 0;
         if ((off - HEADER_BYTES) % unit_bytes() != 0) return 0;
         leaf = (off - HEADER_BYTES) / unit_bytes();
         if (leaf >= (longint'(1) << depth)) return 0;
         return !leaf_written[leaf];
      endfunction

      function result_word_type predict_alloc(logic [21:0] bytes);
         result_word_type r;
         longint unsigned q, leaf;
         int unsigned lvl, d, n, k;
         bit found;
         r = '0;
         r.status = ST_NOSPC;
         q = total_bytes() / (longint'(bytes) + HEADER_BYTES);
         if (q == 0) return r;
         lvl = 0;
         while (q > 1) begin
            q >>= 1;
            lvl++;
         end
         if (lvl > depth) lvl = depth;
         found = 0;
         n = 0;
         d = lvl;
         for (int dd = lvl; dd >= 0 && !found; dd--) begin
            for (int nn = 1 << dd; nn < (2 << dd); nn++) begin
               if (node_free[nn]) begin
                  found = 1;
                  n = nn;
                  d = dd;
                  break;
               end
            end
         end
         if (!found) return r;
         node_free[n] = 0;
         for (k = d; k < lvl; k++) begin
            node_free[2 * n + 1] = 1;
            n = 2 * n;
         end
         node_taken[n] = 1;
         leaf = longint'(n - (1 << lvl)) << (depth - lvl);
         leaf_level[leaf] = 4'(lvl);
         leaf_written[leaf] = 1;
         r.status = ST_OK;
         r.offset = 22'(leaf * unit_bytes() + HEADER_BYTES);
         r.level = 4'(lvl);
         live.push_back(int'(r.offset));
         return r;
      endfunction

      function result_word_type predict_free(logic [21:0] off);
         result_word_type r;
         longint unsigned leaf;
         int unsigned lvl, n, shift;
         r = '0;
         r.status = ST_BADOFF;
         if (off < HEADER_BYTES) return r;
         if ((off - HEADER_BYTES) % unit_bytes() != 0) return r;
         leaf = (off - HEADER_BYTES) / unit_bytes();
         if (leaf >= (longint'(1) << depth)) return r;
         lvl = leaf_level[leaf];
         if (lvl > depth) return r;
         shift = depth - lvl;
         if ((leaf & ((longint'(1) << shift) - 1)) != 0) return r;
         n = (1 << lvl) + 32'(leaf >> shift);
         if (n >= NODE_COUNT || !node_taken[n]) return r;
         node_taken[n] = 0;
         node_free[n] = 1;
         while (n > 1 && node_free[n ^ 1]) begin
            node_free[n] = 0;
            node_free[n ^ 1] = 0;
            n >>= 1;
            node_free[n] = 1;
         end
         r.status = ST_OK;
         r.level = 4'(lvl);
         foreach (live[i]) begin
            if (live[i] == off) begin
               live.delete(i);
               break;
            end
         end
         dead.push_back(int'(off));
         if (dead.size() > 16) void'(dead.pop_front());
         return r;
      endfunction

      function void note_request(logic act, logic [21:0] bytes, logic [21:0] off);
         if (act == ACT_ALLOC) expected_words.push_back(predict_alloc(bytes));
         else expected_words.push_back(predict_free(off));
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         fails++;
      endtask

      task check_word(result_word_type got);
         result_word_type exp;
         if (expected_words.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         exp = expected_words.pop_front();
         if (got.status !== exp.status)
            report($sformatf("status %0d, expected %0d", got.status, exp.status));
         if (got.offset !== exp.offset)
            report($sformatf("data_offset %0d, expected %0d", got.offset, exp.offset));
         if (got.level !== exp.level)
            report($sformatf("block_level %0d, expected %0d", got.level, exp.level));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [21:0] req_request_bytes;
   logic [21:0] req_free_offset;
   logic        rsp_done;
   logic [1:0]  rsp_status;
   logic [21:0] rsp_data_offset;
   logic [3:0]  rsp_block_level;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   alloc_tracker tracker;
   int          burst_left;

   buddy_block_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_request_bytes(req_request_bytes),
      .req_free_offset(req_free_offset), .rsp_done(rsp_done),
      .rsp_status(rsp_status), .rsp_data_offset(rsp_data_offset),
      .rsp_block_level(rsp_block_level), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("buddy_block_allocator_top_test: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_done)
         tracker.check_word({rsp_status, rsp_data_offset, rsp_block_level});
   end

   task send_word(logic act, logic [21:0] bytes, logic [21:0] off);
      req_action <= act;
      req_request_bytes <= bytes;
      req_free_offset <= off;
      start <= 1;
      do @(posedge clock); while (busy);
      tracker.note_request(act, bytes, off);
   endtask

   task drain();
      start <= 0;
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task write_csr(logic [ADDR_BITS-1:0] addr, logic [31:0] value);
      drain();
      psel <= 1;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      tracker.write_reg(addr, value);
   endtask

   // sender pacing: bursts with random gaps, sometimes long gap-free runs
   task pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 30);
      start <= 0;
      repeat (gap) @(posedge clock);
   endtask

   task random_word();
      int r;
      int unsigned k;
      longint unsigned cap;
      logic [21:0] bytes, off;
      r = $urandom_range(0, 99);
      bytes = 22'($urandom);
      off = 22'($urandom);
      if (r < 50 || (r < 85 && tracker.live.size() == 0)) begin
         k = $urandom_range(0, tracker.depth);
         cap = tracker.total_bytes() >> k;
         if (r >= 3) bytes = (cap > 8) ? 22'($urandom_range(0, 32'(cap - 8))) : 22'd0;
         send_word(ACT_ALLOC, bytes, off);
      end else if (r < 85) begin
         send_word(1'b1, bytes,
                   22'(tracker.live[$urandom_range(0, tracker.live.size() - 1)]));
      end else if (r < 92 && tracker.dead.size() != 0) begin
         send_word(1'b1, bytes,
                   22'(tracker.dead[$urandom_range(0, tracker.dead.size() - 1)]));
      end else begin
         if (r < 96 && tracker.live.size() != 0)
            off = 22'(tracker.live[0] + $urandom_range(0, 3) * tracker.unit_bytes()
                      + $urandom_range(0, 1));
         while (tracker.reads_unwritten(off)) off = 22'($urandom);
         send_word(1'b1, bytes, off);
      end
   endtask

   task random_phase(int count, bit hold_once);
      for (int i = 0; i < count; i++) begin
         random_word();
         if (hold_once && i == count / 2) drain();
         else pace();
      end
   endtask

   initial begin
      tracker = new();
      tracker.power_up();
      burst_left = 0;
      reset = 1;
      start = 0;
      req_action = 0;
      req_request_bytes = 0;
      req_free_offset = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed corners at reset settings
      send_word(ACT_ALLOC, 22'd0, 22'd0);
      send_word(ACT_ALLOC, 22'd32760, 22'd0);
      send_word(ACT_ALLOC, 22'd32761, 22'd0);
      send_word(ACT_ALLOC, 22'd2097152, 22'd0);
      send_word(ACT_ALLOC, 22'h3FFFFF, 22'h3FFFFF);
      send_word(1'b1, 22'h3FFFFF, 22'd0);
      send_word(1'b1, 22'd0, 22'd7);
      send_word(1'b1, 22'd0, 22'd9);
      send_word(1'b1, 22'd0, 22'd8 + 22'd64 * 22'd512);
      send_word(1'b1, 22'd0, 22'h3FFFFF);
      send_word(1'b1, 22'd0, 22'd8);
      send_word(1'b1, 22'd0, 22'd8);
      send_word(ACT_ALLOC, 22'd200, 22'd0);
      send_word(ACT_ALLOC, 22'd56, 22'd0);
      send_word(ACT_ALLOC, 22'd16000, 22'd0);
      send_word(ACT_ALLOC, 22'd16000, 22'd0);
      send_word(1'b1, 22'd0, 22'd8);
      send_word(1'b1, 22'd0, 22'd72);
      send_word(1'b1, 22'd0, 22'd16392);
      send_word(ACT_ALLOC, 22'd32760, 22'd0);
      send_word(ACT_ALLOC, 22'd0, 22'd0);
      send_word(1'b1, 22'd0, 22'd8);
      start <= 0;

      random_phase(150, 1);
      write_csr(REG_LEVELS, 32'd0);
      write_csr(REG_MINBLK, 32'd1);
      random_phase(80, 0);
      write_csr(REG_LEVELS, 32'hFFFF_FFFF);
      write_csr(REG_MINBLK, 32'd8191);
      random_phase(160, 0);
      write_csr(REG_MINBLK, 32'd0);
      random_phase(120, 0);
      write_csr(REG_LEVELS, 32'd3);
      write_csr(REG_MINBLK, 32'd4096);
      random_phase(120, 0);
      write_csr(REG_LEVELS, 32'd5);
      write_csr(REG_MINBLK, 32'd13);
      random_phase(140, 0);
      write_csr(REG_LEVELS, 32'd9);
      write_csr(REG_MINBLK, 32'd64);
      random_phase(160, 0);
      write_csr(REG_LEVELS, $urandom_range(1, 9));
      write_csr(REG_MINBLK, $urandom_range(1, 4096));
      random_phase(100, 0);

      drain();
      if (tracker.fails == 0 && tracker.expected_words.size() == 0) begin
         $display("buddy_block_allocator_top_test: PASS");
      end else begin
         $display("buddy_block_allocator_top_test: FAIL");
      end
      $finish;
   end

endmodule
